>>> sv/dxr_pkg.sv
// Shared constants, word layouts and controller/datapath command types
// for the DXR route lookup engine. No dependencies.
`default_nettype none

package dxr_pkg;

  // Table geometry
  localparam int CHUNK_BITS   = 18;
  localparam int RANGE_DEPTH  = 65536;
  localparam int HOP_DEPTH    = 4096;
  localparam int DIRECT_DEPTH = 1 << CHUNK_BITS;
  localparam int OFFSET_BITS  = 32 - CHUNK_BITS;
  localparam int RANGE_AW     = $clog2(RANGE_DEPTH);
  localparam int HOP_AW       = $clog2(HOP_DEPTH);

  // Entry layouts
  localparam int ENTRY_W      = 32;
  localparam int POINTER_BITS = 20;
  localparam int COUNT_BITS   = 12;
  localparam int START_W      = 16;
  localparam int RHOP_W       = 16;
  localparam int HOP_W        = 32;
  localparam int ADDR_W       = 32;

  // Index compares run one bit above the pointer width
  localparam int IDX_W = POINTER_BITS + 1;
  localparam logic [IDX_W-1:0] DIRECT_LIMIT = IDX_W'(DIRECT_DEPTH);
  localparam logic [IDX_W-1:0] RANGE_LIMIT  = IDX_W'(RANGE_DEPTH);
  localparam logic [IDX_W-1:0] HOP_LIMIT    = IDX_W'(HOP_DEPTH);

  // Offset compare width covers both the address offset and a range start
  localparam int OFF_CMP_W = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;

  // Search bound
  localparam int SEARCH_STEPS = 13;
  localparam int STEP_W       = $clog2(SEARCH_STEPS + 1);

  // Stream widths
  localparam int IN_FIELDS_W = ADDR_W + POINTER_BITS + COUNT_BITS + POINTER_BITS
                             + START_W + RHOP_W + HOP_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_DATA_W - IN_FIELDS_W;
  localparam int OUT_DATA_W  = HOP_W;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_RANGE  = 2'd2,
    KIND_HOP    = 2'd3
  } kind_t;

  // Input word, first field in the lowest bits
  typedef struct packed {
    logic [IN_PAD_W-1:0]     pad;
    logic [HOP_W-1:0]        hop_value;
    logic [RHOP_W-1:0]       range_hop_index;
    logic [START_W-1:0]      range_start;
    logic [POINTER_BITS-1:0] chunk_pointer;
    logic [COUNT_BITS-1:0]   chunk_range_count;
    logic [POINTER_BITS-1:0] write_index;
    logic [ADDR_W-1:0]       lookup_address;
  } in_word_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;          // write table entry from the input word
    logic lkp_start;   // latch address, read direct table
    logic dir_load;    // latch direct entry, reset search window
    logic mid_rd;      // latch probe, read range at base + mid
    logic item_load;   // latch probed range entry
    logic next_rd;     // read range at base + mid + 1
    logic below_load;  // latch compare against next range start
    logic narrow;      // shrink search window
    logic hidx_item;   // take hop index from probed range
    logic hop_rd;      // read hop table, clear error
    logic set_err;     // flag error result
    logic out_load;    // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic steps_done;
    logic mid_bad;
    logic mid_last;
    logic next_bad;
    logic hit;
    logic hop_bad;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/dxr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module dxr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/dxr_dp.sv
// Datapath of the DXR route lookup: the three tables, search window,
// probe compares and output register. Depends on dxr_pkg and dxr_ram.
`default_nettype none

module dxr_dp (
  input  wire logic              clk,
  input  wire dxr_pkg::kind_t    kind,
  input  wire dxr_pkg::in_word_t in_word,
  input  wire dxr_pkg::cmd_t     cmd,
  output dxr_pkg::sts_t          sts,
  output logic [dxr_pkg::OUT_DATA_W-1:0] out_next_hop,
  output logic                   out_status
);
  import dxr_pkg::*;

  // Table ports
  logic                    dir_we, rng_we, hop_we;
  logic [ENTRY_W-1:0]      dir_rdata, rng_rdata, hop_rdata;
  logic [ENTRY_W-1:0]      dir_wdata, rng_wdata;
  logic [RANGE_AW-1:0]     rng_raddr;
  logic [IDX_W-1:0]        widx_ext;

  // Search registers
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [POINTER_BITS-1:0] base_r, base_nxt;
  logic [COUNT_BITS-1:0]   lo_r, lo_nxt;
  logic [COUNT_BITS-1:0]   hi_r, hi_nxt;
  logic [COUNT_BITS-1:0]   mid_r, mid_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [ENTRY_W-1:0]      item_r, item_nxt;
  logic                    below_r, below_nxt;
  logic [POINTER_BITS-1:0] hidx_r, hidx_nxt;
  logic                    err_r, err_nxt;
  logic [HOP_W-1:0]        out_hop_r, out_hop_nxt;
  logic                    out_err_r, out_err_nxt;

  // Probe arithmetic
  logic [COUNT_BITS-1:0]   mid;
  logic [IDX_W-1:0]        probe_sum, next_sum;
  logic [OFF_CMP_W-1:0]    off_ext, start_ext, next_start_ext;

  // Write decode; out-of-range writes are dropped
  assign widx_ext  = {1'b0, in_word.write_index};
  assign dir_we    = cmd.wr && (kind == KIND_DIRECT) && (widx_ext < DIRECT_LIMIT);
  assign rng_we    = cmd.wr && (kind == KIND_RANGE)  && (widx_ext < RANGE_LIMIT);
  assign hop_we    = cmd.wr && (kind == KIND_HOP)    && (widx_ext < HOP_LIMIT);
  assign dir_wdata = {in_word.chunk_range_count, in_word.chunk_pointer};
  assign rng_wdata = {in_word.range_hop_index, in_word.range_start};

  // Probe index and bounds
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign probe_sum = {1'b0, base_r} + IDX_W'(mid);
  assign next_sum  = {1'b0, base_r} + IDX_W'(mid_r) + IDX_W'(1);
  assign rng_raddr = cmd.next_rd ? next_sum[RANGE_AW-1:0] : probe_sum[RANGE_AW-1:0];

  assign off_ext        = OFF_CMP_W'(off_r);
  assign start_ext      = OFF_CMP_W'(item_r[START_W-1:0]);
  assign next_start_ext = OFF_CMP_W'(rng_rdata[START_W-1:0]);

  // Status to the controller
  always_comb begin
    sts.count_zero = (dir_rdata[ENTRY_W-1 -: COUNT_BITS] == '0);
    sts.steps_done = (step_r == STEP_W'(SEARCH_STEPS));
    sts.mid_bad    = (mid >= count_r) || (probe_sum >= RANGE_LIMIT);
    sts.mid_last   = (mid_r == (count_r - COUNT_BITS'(1)));
    sts.next_bad   = (next_sum >= RANGE_LIMIT);
    sts.hit        = (off_ext >= start_ext) && below_r;
    sts.hop_bad    = ({1'b0, hidx_r} >= HOP_LIMIT);
  end

  // Next values of the search registers
  always_comb begin
    off_nxt     = off_r;
    count_nxt   = count_r;
    base_nxt    = base_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    step_nxt    = step_r;
    item_nxt    = item_r;
    below_nxt   = below_r;
    hidx_nxt    = hidx_r;
    err_nxt     = err_r;
    out_hop_nxt = out_hop_r;
    out_err_nxt = out_err_r;
    if (cmd.lkp_start) begin
      off_nxt = in_word.lookup_address[OFFSET_BITS-1:0];
    end
    if (cmd.dir_load) begin
      count_nxt = dir_rdata[ENTRY_W-1 -: COUNT_BITS];
      base_nxt  = dir_rdata[POINTER_BITS-1:0];
      hidx_nxt  = dir_rdata[POINTER_BITS-1:0];
      lo_nxt    = '0;
      hi_nxt    = dir_rdata[ENTRY_W-1 -: COUNT_BITS];
      step_nxt  = '0;
    end
    if (cmd.mid_rd) begin
      mid_nxt = mid;
    end
    // Last range of the chunk has no upper bound
    if (cmd.item_load) begin
      item_nxt  = rng_rdata;
      below_nxt = 1'b1;
    end
    if (cmd.below_load) begin
      below_nxt = off_ext < next_start_ext;
    end
    if (cmd.narrow) begin
      if (off_ext <= start_ext) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r + COUNT_BITS'(1);
      end
      step_nxt = step_r + STEP_W'(1);
    end
    if (cmd.hidx_item) begin
      hidx_nxt = POINTER_BITS'(item_r[ENTRY_W-1 -: RHOP_W]);
    end
    if (cmd.hop_rd) begin
      err_nxt = 1'b0;
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    // Error results carry a zero next hop
    if (cmd.out_load) begin
      out_hop_nxt = err_r ? '0 : hop_rdata;
      out_err_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    off_r     <= off_nxt;
    count_r   <= count_nxt;
    base_r    <= base_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    step_r    <= step_nxt;
    item_r    <= item_nxt;
    below_r   <= below_nxt;
    hidx_r    <= hidx_nxt;
    err_r     <= err_nxt;
    out_hop_r <= out_hop_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_next_hop = out_hop_r;
  assign out_status   = out_err_r;

  // Direct table: one entry per chunk
  dxr_ram #(.WIDTH(ENTRY_W), .DEPTH(DIRECT_DEPTH)) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_we),
    .wr_addr (in_word.write_index[CHUNK_BITS-1:0]),
    .wr_data (dir_wdata),
    .rd_en   (cmd.lkp_start),
    .rd_addr (in_word.lookup_address[ADDR_W-1 -: CHUNK_BITS]),
    .rd_data (dir_rdata)
  );

  // Range table: start and hop index per range
  dxr_ram #(.WIDTH(ENTRY_W), .DEPTH(RANGE_DEPTH)) u_rng_ram (
    .clk     (clk),
    .wr_en   (rng_we),
    .wr_addr (in_word.write_index[RANGE_AW-1:0]),
    .wr_data (rng_wdata),
    .rd_en   (cmd.mid_rd || cmd.next_rd),
    .rd_addr (rng_raddr),
    .rd_data (rng_rdata)
  );

  // Next-hop table
  dxr_ram #(.WIDTH(HOP_W), .DEPTH(HOP_DEPTH)) u_hop_ram (
    .clk     (clk),
    .wr_en   (hop_we),
    .wr_addr (in_word.write_index[HOP_AW-1:0]),
    .wr_data (in_word.hop_value),
    .rd_en   (cmd.hop_rd),
    .rd_addr (hidx_r[HOP_AW-1:0]),
    .rd_data (hop_rdata)
  );

endmodule

`default_nettype wire

>>> sv/dxr_ctrl.sv
// Controller of the DXR route lookup: sequences table writes, the direct
// read, the bounded binary search and the hop read. Depends on dxr_pkg.
`default_nettype none

module dxr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire dxr_pkg::kind_t kind,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire dxr_pkg::sts_t  sts,
  output dxr_pkg::cmd_t       cmd
);
  import dxr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIR  = 8'b0000_0010,
    S_MID  = 8'b0000_0100,
    S_RD1  = 8'b0000_1000,
    S_RD2  = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_HOP  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_LOOKUP) begin
            cmd.lkp_start = 1'b1;
            state_nxt     = S_DIR;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_DIR: begin
        cmd.dir_load = 1'b1;
        state_nxt    = sts.count_zero ? S_HOP : S_MID;
      end
      S_MID: begin
        if (sts.steps_done || sts.mid_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.mid_rd = 1'b1;
          state_nxt  = S_RD1;
        end
      end
      S_RD1: begin
        cmd.item_load = 1'b1;
        if (sts.mid_last) begin
          state_nxt = S_CMP;
        end else if (sts.next_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.next_rd = 1'b1;
          state_nxt   = S_RD2;
        end
      end
      S_RD2: begin
        cmd.below_load = 1'b1;
        state_nxt      = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.hidx_item = 1'b1;
          state_nxt     = S_HOP;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = S_MID;
        end
      end
      S_HOP: begin
        if (sts.hop_bad) begin
          cmd.set_err = 1'b1;
        end else begin
          cmd.hop_rd = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/dxr_route_lookup.sv
// Top level of the DXR route lookup engine: controller plus datapath.
// Depends on dxr_pkg, dxr_ctrl, dxr_dp and dxr_ram.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   in_     | in  | in_tvalid/tready   | tuser kind, tdata table or lookup
//   out_    | out | out_tvalid/tready  | tdata next hop, tuser status
//
// A table write completes in the cycle its word is accepted. A lookup holds
// the input through the direct read, at most 13 binary-search probes and,
// unless it fails, the hop read; a probe reads the range table's single read
// port twice, or once when it lands on the last range of the chunk. Reset
// clears only the controller; tables are not cleared. A stalled output holds
// one result while the next word is taken.
`default_nettype none

module dxr_route_lookup (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // in_tdata, low bit up: lookup_address, write_index, chunk_range_count,
  // chunk_pointer, range_start, range_hop_index, hop_value, zero pad
  input  wire logic [dxr_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind
  input  wire logic [1:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_tdata: next_hop
  output logic [dxr_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: status
  output logic                                out_tuser
);
  import dxr_pkg::*;

  kind_t    kind;
  in_word_t in_word;
  cmd_t     cmd;
  sts_t     sts;

  assign kind    = kind_t'(in_tuser);
  assign in_word = in_word_t'(in_tdata);

  dxr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .kind       (kind),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dxr_dp u_dp (
    .clk          (clk),
    .kind         (kind),
    .in_word      (in_word),
    .cmd          (cmd),
    .sts          (sts),
    .out_next_hop (out_tdata),
    .out_status   (out_tuser)
  );

`ifndef ASSERT_OFF
  // Never overwrite a result that is still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

  // Table writes happen only on an accepted word
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (in_tvalid && in_tready && (kind != KIND_LOOKUP)))
    else $error("table write without an accepted write word");

  // An accepted lookup latches its direct entry next cycle
  a_lookup_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (kind == KIND_LOOKUP)) |=> cmd.dir_load)
    else $error("lookup did not read its direct entry");

  // Hop read and error flag never meet
  a_hop_or_err: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hop_rd && cmd.set_err))
    else $error("hop read issued on an error path");
`endif

endmodule

`default_nettype wire
